[rtl/dopq_pkg.sv]
// Types, codes and key helper shared by the date-ordered priority queue.
package dopq_pkg;

    typedef enum logic [1:0] {
        FUNC_ENQ    = 2'd0,
        FUNC_DEQ    = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_HREAD,
        S_HOUT
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [15:0] group_tag;
        logic [7:0]  group_size;
        logic [3:0]  month_rank;
        logic [4:0]  day_of_month;
        logic [15:0] cost;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic        head_valid;
        logic [15:0] head_tag;
        logic [7:0]  head_size;
        logic [3:0]  head_month;
        logic [4:0]  head_day;
        logic [15:0] head_cost;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  size;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int KEY_W   = 17;

    // month, then day, then size; larger sorts later
    function automatic logic [KEY_W-1:0] key_of(entry_t e);
        return {e.month, e.day, e.size};
    endfunction

endpackage

[rtl/dopq_ram.sv]
// Generic simple dual-port RAM with registered read.
module dopq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/date_ordered_priority_queue_unit.sv]
// Date-ordered priority queue: sorted entry RAM walked by a small sequencer.
// Query and error cases go straight to the head read (S_HREAD, then S_HOUT);
// enqueue, dequeue and cancel first walk the entry RAM in S_SCAN when entries must
// be scanned (one RAM entry per cycle); busy drops after done, so one request at a time.
// Reset clears the count and the sequencer; RAM contents are not cleared.
// One result per request, shown for one cycle; the receiver cannot stall.
module date_ordered_priority_queue_unit
    import dopq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t           state_reg,  state_next;
    request_t         req_reg,    req_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    status_t          status_reg, status_next;
    logic             found_reg,  found_next;
    logic             iss_en_reg, iss_en_next;
    logic [AW-1:0]    iss_ptr_reg, iss_ptr_next;
    logic             pend_reg,   pend_next;
    logic [AW-1:0]    pidx_reg,   pidx_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    entry_t           item;
    entry_t           new_ent;
    entry_t           rd_ent;
    logic [AW-1:0]    cnt_last;
    logic             cnt_full;
    logic             match;
    logic [31:0]      cnt_ext;

    dopq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item    = '{tag: req_reg.group_tag, size: req_reg.group_size,
                       month: req_reg.month_rank, day: req_reg.day_of_month,
                       cost: req_reg.cost};
    assign new_ent = '{tag: request.group_tag, size: request.group_size,
                       month: request.month_rank, day: request.day_of_month,
                       cost: request.cost};
    assign rd_ent   = entry_t'(rd_data);
    assign cnt_last = AW'(cnt_reg - 1'b1);
    assign cnt_full = (cnt_reg == CW'(DEPTH));
    assign match    = (rd_ent.tag == item.tag) && (rd_ent.month == item.month)
                      && (rd_ent.day == item.day);
    assign cnt_ext  = 32'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            iss_en_reg <= 1'b0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            iss_en_reg <= iss_en_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        iss_ptr_reg <= iss_ptr_next;
        pidx_reg    <= pidx_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        iss_en_next  = iss_en_reg;
        iss_ptr_next = iss_ptr_reg;
        pend_next    = 1'b0;
        pidx_next    = iss_ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = item;
        rd_addr      = iss_ptr_reg;
        done         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    iss_en_next = 1'b0;
                    state_next  = S_HREAD;
                    unique case (request.func)
                        FUNC_ENQ:
                        begin
                            if (cnt_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = '0;
                                wr_data  = new_ent;
                                cnt_next = CW'(cnt_reg + 1'b1);
                            end
                            else
                            begin
                                // walk backward from the tail
                                iss_en_next  = 1'b1;
                                iss_ptr_next = cnt_last;
                                state_next   = S_SCAN;
                            end
                        end
                        FUNC_DEQ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                // head counts as the removed entry
                                found_next   = 1'b1;
                                iss_en_next  = 1'b1;
                                iss_ptr_next = AW'(1);
                                state_next   = S_SCAN;
                            end
                        end
                        FUNC_CANCEL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                iss_en_next  = 1'b1;
                                iss_ptr_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            state_next = S_HREAD;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                pend_next = iss_en_reg;
                if (iss_en_reg)
                begin
                    if (req_reg.func == FUNC_ENQ)
                    begin
                        if (iss_ptr_reg == '0)
                        begin
                            iss_en_next = 1'b0;
                        end
                        else
                        begin
                            iss_ptr_next = AW'(iss_ptr_reg - 1'b1);
                        end
                    end
                    else
                    begin
                        if (iss_ptr_reg == cnt_last)
                        begin
                            iss_en_next = 1'b0;
                        end
                        else
                        begin
                            iss_ptr_next = AW'(iss_ptr_reg + 1'b1);
                        end
                    end
                end

                if (pend_reg)
                begin
                    if (req_reg.func == FUNC_ENQ)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(pidx_reg + 1'b1);
                        if (key_of(rd_ent) > key_of(item))
                        begin
                            wr_data = rd_ent;
                            if (pidx_reg == '0)
                            begin
                                iss_en_next = 1'b0;
                                pend_next   = 1'b0;
                                state_next  = S_PLACE;
                            end
                        end
                        else
                        begin
                            wr_data     = item;
                            cnt_next    = CW'(cnt_reg + 1'b1);
                            iss_en_next = 1'b0;
                            pend_next   = 1'b0;
                            state_next  = S_HREAD;
                        end
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(pidx_reg - 1'b1);
                            wr_data = rd_ent;
                        end
                        else if (match)
                        begin
                            found_next = 1'b1;
                        end
                        if (pidx_reg == cnt_last)
                        begin
                            if (found_reg || match)
                            begin
                                cnt_next = CW'(cnt_reg - 1'b1);
                            end
                            else
                            begin
                                status_next = ST_NO_MATCH;
                            end
                            iss_en_next = 1'b0;
                            pend_next   = 1'b0;
                            state_next  = S_HREAD;
                        end
                    end
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = item;
                cnt_next   = CW'(cnt_reg + 1'b1);
                state_next = S_HREAD;
            end

            S_HREAD:
            begin
                rd_addr    = '0;
                state_next = S_HOUT;
            end

            S_HOUT:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        result             = '0;
        result.status      = status_reg;
        result.entry_count = cnt_ext[4:0];
        if (cnt_reg != '0)
        begin
            result.head_valid = 1'b1;
            result.head_tag   = rd_ent.tag;
            result.head_size  = rd_ent.size;
            result.head_month = rd_ent.month;
            result.head_day   = rd_ent.day;
            result.head_cost  = rd_ent.cost;
        end
    end

endmodule
